FILE: rtl/opfal_pkg.sv
// shared constants and types for the object pool free/active list core
package opfal_pkg;
    localparam int NumPools   = 8;
    localparam int PoolSlots  = 64;
    localparam int PoolW      = $clog2(NumPools);
    localparam int SlotW      = $clog2(PoolSlots);
    localparam int LinkW      = SlotW + 1;
    localparam int MemDepth   = NumPools * PoolSlots;
    localparam int MemAw      = $clog2(MemDepth);

    localparam logic [2:0] OP_RESET = 3'd0;
    localparam logic [2:0] OP_ALLOC = 3'd1;
    localparam logic [2:0] OP_CLEAR = 3'd2;
    localparam logic [2:0] OP_START = 3'd3;
    localparam logic [2:0] OP_STEP  = 3'd4;

    localparam logic [LinkW-1:0] NULL_LINK = LinkW'(PoolSlots);

    typedef logic [LinkW-1:0] t_link;
endpackage

FILE: rtl/object_pool_free_active_lists_core.sv
// object pool core: per-pool free and active linked lists in one shared link memory
//
//  channel | signals                                             | dir
//  in      | i_valid o_ready i_opcode i_pool_id i_slot_count i_keep | in
//  out     | o_valid i_ready o_slot_index o_slot_valid o_walk_done o_pool_empty | out
//
// start, failed allocate, idle walk step, other opcodes: result straight from idle
// allocate, keep step: read, write back, result; release: read, unlink, relink, result
// reset pool: one link write per slot; clear: a read and a write back per active slot
// one item is in work at a time; the next is taken the cycle after its result is registered
// a waiting result stalls the next finished item in done, and the input with it
// synchronous active-low reset empties all lists; the link memory is not cleared
module object_pool_free_active_lists_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [2:0] i_opcode,
    input  logic [2:0] i_pool_id,
    input  logic [6:0] i_slot_count,
    input  logic       i_keep,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [5:0] o_slot_index,
    output logic       o_slot_valid,
    output logic       o_walk_done,
    output logic       o_pool_empty
);
    import opfal_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FILL  = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_WB    = 3'd3;
    localparam logic [2:0] S_CLR   = 3'd4;
    localparam logic [2:0] S_CLRWB = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [LinkW-1:0] r_mem [MemDepth];
    logic [LinkW-1:0] r_rdata;
    logic             mem_we;
    logic [MemAw-1:0] mem_waddr, mem_raddr;
    logic [LinkW-1:0] mem_wdata;

    t_link            r_free [NumPools];
    t_link            r_act  [NumPools];
    logic [PoolW-1:0] r_walk_pool;
    t_link            r_walk_cur, r_walk_prev;
    logic             r_walk_run;

    logic [2:0]       r_state;
    logic [2:0]       r_op;
    logic [PoolW-1:0] r_p;
    logic             r_keep;
    logic [LinkW-1:0] r_cap, r_cnt;
    logic             r_wb2;
    logic             r_valid;
    logic [5:0]       r_idx;
    logic             r_sv, r_done, r_empty;
    logic [5:0]       r_out_idx;
    logic             r_out_sv, r_out_done;

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        r_rdata <= r_mem[mem_raddr];
    end

    function automatic logic [MemAw-1:0] maddr(logic [PoolW-1:0] p, t_link s);
        return {p, s[SlotW-1:0]};
    endfunction

    function automatic t_link nrm(t_link v);
        return v[SlotW] ? NULL_LINK : v;
    endfunction

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_valid;
    assign o_slot_index = r_out_idx;
    assign o_slot_valid = r_out_sv;
    assign o_walk_done = r_out_done;
    assign o_pool_empty = r_empty;

    logic [PoolW-1:0] wq;
    t_link            rd_n;
    assign wq   = (r_op == OP_STEP) ? r_walk_pool : r_p;
    assign rd_n = nrm(r_rdata);

    // memory port control
    always_comb begin
        mem_we = 1'b0; mem_waddr = '0; mem_wdata = '0; mem_raddr = '0;
        case (r_state)
            S_FILL: begin
                mem_we = 1'b1;
                mem_waddr = maddr(r_p, r_cnt);
                mem_wdata = (r_cnt + 1'b1 == r_cap) ? NULL_LINK : r_cnt + 1'b1;
            end
            S_RD: begin
                if (r_op == OP_ALLOC) mem_raddr = maddr(r_p, r_free[r_p]);
                else mem_raddr = maddr(r_walk_pool, r_walk_cur);
            end
            S_CLR: mem_raddr = maddr(r_p, r_act[r_p]);
            S_WB: begin
                if (r_op == OP_ALLOC) begin
                    mem_we = 1'b1;
                    mem_waddr = maddr(r_p, r_free[r_p]);
                    mem_wdata = r_act[r_p];
                end else if (!r_keep) begin
                    if (!r_wb2) begin
                        // unlink from predecessor when one exists
                        mem_we = (r_walk_prev != NULL_LINK);
                        mem_waddr = maddr(wq, r_walk_prev);
                        mem_wdata = rd_n;
                    end else begin
                        mem_we = 1'b1;
                        mem_waddr = maddr(wq, r_walk_cur);
                        mem_wdata = r_free[wq];
                    end
                end
            end
            S_CLRWB: begin
                mem_we = 1'b1;
                mem_waddr = maddr(r_p, r_act[r_p]);
                mem_wdata = r_free[r_p];
            end
            default: ;
        endcase
    end

    t_link cap_n;
    always_comb begin
        if (i_slot_count == '0) cap_n = LinkW'(1);
        else if (i_slot_count > 7'(PoolSlots)) cap_n = NULL_LINK;
        else cap_n = LinkW'(i_slot_count);
    end

    logic [LinkW-1:0] r_nxt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_walk_run <= 1'b0;
            r_walk_pool <= '0;
            r_walk_cur <= NULL_LINK;
            r_walk_prev <= NULL_LINK;
            for (int k = 0; k < NumPools; k++) begin
                r_free[k] <= NULL_LINK;
                r_act[k] <= NULL_LINK;
            end
        end else begin
            // done state only leaves once the output register is free
            if (r_state == S_DONE) r_valid <= 1'b1;
            else if (i_ready) r_valid <= 1'b0;
            case (r_state)
                S_IDLE: if (i_valid && o_ready) begin
                    r_op <= i_opcode; r_p <= i_pool_id; r_keep <= i_keep;
                    r_cap <= cap_n; r_cnt <= '0; r_wb2 <= 1'b0;
                    r_idx <= '0; r_sv <= 1'b0; r_done <= 1'b0;
                    if (i_opcode == OP_STEP) begin
                        if (r_walk_run) r_state <= S_RD;
                        else begin
                            r_done <= 1'b1; r_state <= S_DONE;
                        end
                    end else if (i_pool_id > 3'(NumPools - 1)) begin
                        r_state <= S_DONE;
                    end else begin
                        case (i_opcode)
                            OP_RESET: begin
                                r_state <= S_FILL;
                                if (r_walk_run && r_walk_pool == i_pool_id)
                                    r_walk_run <= 1'b0;
                            end
                            OP_ALLOC: r_state <= (r_free[i_pool_id] == NULL_LINK) ?
                                                  S_DONE : S_RD;
                            OP_CLEAR: begin
                                r_state <= S_CLR;
                                if (r_walk_run && r_walk_pool == i_pool_id)
                                    r_walk_run <= 1'b0;
                            end
                            OP_START: begin
                                r_walk_pool <= i_pool_id;
                                r_walk_prev <= NULL_LINK;
                                r_walk_cur <= r_act[i_pool_id];
                                r_walk_run <= (r_act[i_pool_id] != NULL_LINK);
                                if (r_act[i_pool_id] != NULL_LINK) begin
                                    r_idx <= r_act[i_pool_id][SlotW-1:0];
                                    r_sv <= 1'b1;
                                end else r_done <= 1'b1;
                                r_state <= S_DONE;
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_FILL: begin
                    if (r_cnt + 1'b1 == r_cap) begin
                        r_free[r_p] <= '0;
                        r_act[r_p] <= NULL_LINK;
                        r_state <= S_DONE;
                    end
                    r_cnt <= r_cnt + 1'b1;
                end
                S_RD: r_state <= S_WB;
                S_WB: begin
                    if (r_op == OP_ALLOC) begin
                        r_idx <= r_free[r_p][SlotW-1:0];
                        r_sv <= 1'b1;
                        r_free[r_p] <= rd_n;
                        r_act[r_p] <= r_free[r_p];
                        if (r_walk_run && r_walk_pool == r_p && r_walk_prev == NULL_LINK)
                            r_walk_prev <= r_free[r_p];
                        r_state <= S_DONE;
                    end else if (r_keep || r_wb2) begin
                        // finish step; r_nxt holds next for release path
                        if (r_keep) begin
                            r_walk_prev <= r_walk_cur;
                        end else begin
                            r_free[wq] <= r_walk_cur;
                        end
                        r_walk_cur <= r_keep ? rd_n : r_nxt;
                        if ((r_keep ? rd_n : r_nxt) == NULL_LINK) begin
                            r_walk_run <= 1'b0; r_done <= 1'b1;
                        end else begin
                            r_idx <= r_keep ? rd_n[SlotW-1:0] : r_nxt[SlotW-1:0];
                            r_sv <= 1'b1;
                        end
                        r_state <= S_DONE;
                    end else begin
                        r_nxt <= rd_n;
                        if (r_walk_prev == NULL_LINK) r_act[wq] <= rd_n;
                        r_wb2 <= 1'b1;
                    end
                end
                S_CLR: begin
                    if (r_act[r_p] == NULL_LINK) r_state <= S_DONE;
                    else r_state <= S_CLRWB;
                end
                S_CLRWB: begin
                    r_act[r_p] <= rd_n;
                    r_free[r_p] <= r_act[r_p];
                    r_state <= S_CLR;
                end
                S_DONE: begin
                    if (!r_valid || i_ready) begin
                        r_out_idx <= r_idx;
                        r_out_sv <= r_sv;
                        r_out_done <= r_done;
                        r_empty <= (r_op != OP_STEP && r_p > 3'(NumPools - 1)) ? 1'b1 :
                                   (r_act[wq] == NULL_LINK);
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_done_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_slot_valid && o_walk_done))
        else $error("slot_valid and walk_done together");
    a_ready_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second transfer while busy");
    a_walk_cur: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_walk_run |-> (r_walk_cur != NULL_LINK))
        else $error("running walk without current slot");
endmodule

FILE: test/object_pool_free_active_lists_core_tb.sv
// testbench for the object pool free/active list core: directed and random pool operations checked against a predictor
`timescale 1ns / 1ps

module object_pool_free_active_lists_core_tb;
    import opfal_pkg::*;

    typedef struct packed {
        logic [2:0] opcode;
        logic [2:0] pool_id;
        logic [6:0] slot_count;
        logic       keep;
    } t_op;

    typedef struct packed {
        logic [5:0] slot_index;
        logic       slot_valid;
        logic       walk_done;
        logic       pool_empty;
    } t_res;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [2:0] i_opcode;
    logic [2:0] i_pool_id;
    logic [6:0] i_slot_count;
    logic       i_keep;
    logic       o_valid;
    logic       i_ready;
    logic [5:0] o_slot_index;
    logic       o_slot_valid;
    logic       o_walk_done;
    logic       o_pool_empty;

    object_pool_free_active_lists_core uut (.*);

    // predictor state
    t_link links [NumPools][PoolSlots];
    t_link free_top [NumPools];
    t_link active_top [NumPools];
    int    walk_pool;
    t_link walk_cur;
    t_link walk_prev;
    bit    walk_on;

    t_op   pending_ops [$];
    t_res  expected_results [$];
    int    errors = 0;
    int    send_idle_pct = 0;
    int    recv_stall_pct = 0;
    int    hold_off = 0;

    function automatic t_link link_rd(int p, t_link s);
        if (s >= NULL_LINK) return NULL_LINK;
        return (links[p][s] >= NULL_LINK) ? NULL_LINK : links[p][s];
    endfunction

    function automatic void link_wr(int p, t_link s, t_link v);
        if (s < NULL_LINK) links[p][s] = v;
    endfunction

    function automatic t_res predict_pool_op(t_op it);
        t_res r;
        int   q;
        int   c;
        t_link cur, nxt, s;
        bit   walked;
        r = '0;
        q = it.pool_id;
        if (it.opcode == OP_STEP) begin
            q = walk_pool;
            if (!walk_on) begin
                r.walk_done = 1;
            end else begin
                cur = walk_cur;
                nxt = link_rd(q, cur);
                if (it.keep) begin
                    walk_prev = cur;
                end else begin
                    if (walk_prev == NULL_LINK) active_top[q] = nxt;
                    else link_wr(q, walk_prev, nxt);
                    link_wr(q, cur, free_top[q]);
                    free_top[q] = cur;
                end
                walk_cur = nxt;
                if (nxt == NULL_LINK) begin
                    walk_on = 0;
                    r.walk_done = 1;
                end else begin
                    r.slot_index = nxt[5:0];
                    r.slot_valid = 1;
                end
            end
        end else if (q < NumPools) begin
            walked = walk_on && walk_pool == q;
            case (it.opcode)
                OP_RESET: begin
                    c = (it.slot_count == 0) ? 1 : it.slot_count;
                    if (c > PoolSlots) c = PoolSlots;
                    for (int i = 0; i < c - 1; i++) links[q][i] = t_link'(i + 1);
                    links[q][c - 1] = NULL_LINK;
                    free_top[q] = 0;
                    active_top[q] = NULL_LINK;
                    if (walked) walk_on = 0;
                end
                OP_ALLOC: begin
                    s = free_top[q];
                    if (s != NULL_LINK) begin
                        free_top[q] = link_rd(q, s);
                        link_wr(q, s, active_top[q]);
                        active_top[q] = s;
                        if (walked && walk_prev == NULL_LINK) walk_prev = s;
                        r.slot_index = s[5:0];
                        r.slot_valid = 1;
                    end
                end
                OP_CLEAR: begin
                    for (int i = 0; i < PoolSlots && active_top[q] != NULL_LINK; i++) begin
                        s = active_top[q];
                        active_top[q] = link_rd(q, s);
                        link_wr(q, s, free_top[q]);
                        free_top[q] = s;
                    end
                    active_top[q] = NULL_LINK;
                    if (walked) walk_on = 0;
                end
                OP_START: begin
                    walk_pool = q;
                    walk_prev = NULL_LINK;
                    walk_cur = active_top[q];
                    walk_on = walk_cur != NULL_LINK;
                    if (walk_on) begin
                        r.slot_index = walk_cur[5:0];
                        r.slot_valid = 1;
                    end else begin
                        r.walk_done = 1;
                    end
                end
                default: ;
            endcase
        end
        r.pool_empty = (q >= NumPools || active_top[q] == NULL_LINK);
        return r;
    endfunction

    function automatic t_op mk(logic [2:0] op, int p, int cnt, bit k);
        t_op it;
        it.opcode = op;
        it.pool_id = 3'(p);
        it.slot_count = 7'(cnt);
        it.keep = k;
        return it;
    endfunction

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    // driver
    initial begin
        i_valid = 0;
        i_opcode = '0;
        i_pool_id = '0;
        i_slot_count = '0;
        i_keep = 0;
        i_ready = 0;
        i_rst_n = 0;
        for (int p = 0; p < NumPools; p++) begin
            free_top[p] = NULL_LINK;
            active_top[p] = NULL_LINK;
        end
        walk_pool = 0;
        walk_cur = NULL_LINK;
        walk_prev = NULL_LINK;
        walk_on = 0;
    end

    // ready as seen at the last rising edge, so the driver knows whether the item left
    logic o_ready_q;
    always @(posedge i_clk) o_ready_q <= o_ready;

    always @(negedge i_clk) begin
        if (i_rst_n && !(i_valid && !o_ready_q)) begin
            if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                t_op it;
                it = pending_ops.pop_front();
                i_valid <= 1;
                i_opcode <= it.opcode;
                i_pool_id <= it.pool_id;
                i_slot_count <= it.slot_count;
                i_keep <= it.keep;
            end else begin
                i_valid <= 0;
            end
        end
    end

    // receiver side, with its own hold-off counter
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            i_ready <= 0;
            hold_off <= hold_off - 1;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                expected_results.push_back(predict_pool_op(
                    mk(i_opcode, i_pool_id, i_slot_count, i_keep)));
            end
            if (o_valid && i_ready) begin
                t_res got, exp_r;
                got = {o_slot_index, o_slot_valid, o_walk_done, o_pool_empty};
                if (expected_results.size() == 0) begin
                    $display("%0t: result with none expected, actual %h", $time, got);
                    errors++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got.slot_index !== exp_r.slot_index)
                        $display("%0t: slot_index expected %0d actual %0d", $time,
                                 exp_r.slot_index, got.slot_index);
                    if (got.slot_valid !== exp_r.slot_valid)
                        $display("%0t: slot_valid expected %0d actual %0d", $time,
                                 exp_r.slot_valid, got.slot_valid);
                    if (got.walk_done !== exp_r.walk_done)
                        $display("%0t: walk_done expected %0d actual %0d", $time,
                                 exp_r.walk_done, got.walk_done);
                    if (got.pool_empty !== exp_r.pool_empty)
                        $display("%0t: pool_empty expected %0d actual %0d", $time,
                                 exp_r.pool_empty, got.pool_empty);
                    if (got !== exp_r) errors++;
                end
            end
        end
    end

    // random walk-heavy sequence: resets, a few allocs, walks with random keep, clears and noise
    task automatic add_random_ops(int n);
        int p, k;
        while (n > 0) begin
            p = $urandom_range(NumPools - 1);
            case ($urandom_range(9))
                0: begin
                    pending_ops.push_back(mk(OP_RESET, p,
                        ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(12), 0));
                    n--;
                end
                1, 2, 3: begin
                    k = $urandom_range(1, 6);
                    repeat (k) pending_ops.push_back(mk(OP_ALLOC, p, $urandom_range(127),
                                                       $urandom_range(1)));
                    n -= k;
                end
                4, 5, 6: begin
                    pending_ops.push_back(mk(OP_START, p, $urandom_range(127), $urandom_range(1)));
                    k = $urandom_range(1, 8);
                    repeat (k) pending_ops.push_back(mk(OP_STEP, $urandom_range(7),
                                                       $urandom_range(127), $urandom_range(1)));
                    n -= k + 1;
                end
                7: begin
                    pending_ops.push_back(mk(OP_CLEAR, p, 0, 0));
                    n--;
                end
                default: begin
                    // noise: any field values, including undefined opcodes
                    pending_ops.push_back(mk(3'($urandom_range(7)), $urandom_range(7),
                                             $urandom_range(127), $urandom_range(1)));
                    n--;
                end
            endcase
        end
    endtask

    task automatic drain();
        while (pending_ops.size() > 0 || expected_results.size() > 0 || i_valid)
            @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: unreset pool, capacity extremes, walk corner cases
        pending_ops.push_back(mk(OP_ALLOC, 2, 0, 0));
        pending_ops.push_back(mk(OP_STEP, 0, 0, 0));
        pending_ops.push_back(mk(OP_RESET, 0, 0, 0));
        pending_ops.push_back(mk(OP_ALLOC, 0, 0, 0));
        pending_ops.push_back(mk(OP_ALLOC, 0, 0, 0));
        pending_ops.push_back(mk(OP_RESET, 7, 127, 1));
        pending_ops.push_back(mk(OP_RESET, 1, 64, 0));
        pending_ops.push_back(mk(OP_ALLOC, 1, 0, 0));
        pending_ops.push_back(mk(OP_ALLOC, 1, 0, 0));
        pending_ops.push_back(mk(OP_START, 1, 0, 0));
        pending_ops.push_back(mk(OP_ALLOC, 1, 0, 0));
        pending_ops.push_back(mk(OP_STEP, 0, 0, 0));
        pending_ops.push_back(mk(OP_STEP, 0, 0, 1));
        pending_ops.push_back(mk(OP_STEP, 0, 0, 1));
        pending_ops.push_back(mk(OP_START, 1, 0, 0));
        pending_ops.push_back(mk(OP_CLEAR, 1, 0, 0));
        pending_ops.push_back(mk(OP_STEP, 0, 0, 0));
        pending_ops.push_back(mk(3'd5, 1, 0, 0));
        pending_ops.push_back(mk(3'd7, 6, 127, 1));
        pending_ops.push_back(mk(OP_START, 3, 0, 0));
        pending_ops.push_back(mk(OP_RESET, 1, 2, 0));
        pending_ops.push_back(mk(OP_ALLOC, 1, 0, 0));
        pending_ops.push_back(mk(OP_START, 1, 0, 0));
        pending_ops.push_back(mk(OP_RESET, 1, 5, 0));
        pending_ops.push_back(mk(OP_STEP, 0, 0, 1));
        add_random_ops(400);
        drain();

        send_idle_pct = 67;
        add_random_ops(450);
        drain();

        send_idle_pct = 0;
        recv_stall_pct = 67;
        add_random_ops(450);
        drain();

        // long receiver hold-off while items keep coming
        recv_stall_pct = 0;
        hold_off = 300;
        add_random_ops(100);
        drain();

        send_idle_pct = 10;
        recv_stall_pct = 10;
        add_random_ops(400);
        drain();

        if (errors == 0 && expected_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end
endmodule

FILE: files.f
rtl/opfal_pkg.sv
rtl/object_pool_free_active_lists_core.sv
test/object_pool_free_active_lists_core_tb.sv
